[rtl/train_pwm_ramp_sequencer_top_macros.svh]
// ----------------------------------------------------------------------------
// Train PWM ramp sequencer assertion macros
// Shared assertion forms for the sequencer RTL.
// ----------------------------------------------------------------------------
`ifndef TRAIN_PWM_RAMP_SEQUENCER_TOP_MACROS_SVH
`define TRAIN_PWM_RAMP_SEQUENCER_TOP_MACROS_SVH

// Condition holds in the same cycle as the trigger.
`define TRPS_ASSERT_SAME(label, clk, rst_n, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("sequencer assertion failed");

// Condition holds in the cycle after the trigger.
`define TRPS_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("sequencer assertion failed");

`endif

[rtl/trps_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Train PWM ramp sequencer package
// Function codes, contact codes, register indexes, phases and result flags.
// ----------------------------------------------------------------------------
package trps_pkg;

  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_RIGHT = 2'd1,
    FUNC_LEFT  = 2'd2,
    FUNC_BRAKE = 2'd3
  } func_t;

  localparam logic [2:0] CONTACT_RIGHT_DOWN = 3'd1;
  localparam logic [2:0] CONTACT_RIGHT_UP   = 3'd2;
  localparam logic [2:0] CONTACT_LEFT_UP    = 3'd3;
  localparam logic [2:0] CONTACT_LEFT_DOWN  = 3'd4;

  localparam int unsigned CFG_ADDR_W = 3;

  localparam logic [CFG_ADDR_W-1:0] CFG_LIGHTS_WAIT    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_STATIONARY     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_TRAIN_WAIT     = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_CRUISE         = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_RAMP_INTERVAL  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_BRAKE_INTERVAL = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_DOWNHILL_LIMIT = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] CFG_UPHILL_LIMIT   = 3'd7;

  typedef enum logic [3:0] {
    PH_FIRST  = 4'b0001,
    PH_SECOND = 4'b0010,
    PH_THIRD  = 4'b0100,
    PH_FOURTH = 4'b1000
  } phase_t;

  typedef struct packed {
    logic done_res;
    logic brake_on;
    logic brake_write;
    logic pwm_write;
  } flags_t;

endpackage

[rtl/trps_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sequencer configuration registers
// Holds the wait, interval and level settings written through the cfg port.
// ----------------------------------------------------------------------------
module trps_cfg #(
  parameter int unsigned PWM_BITS   = 10,
  parameter int unsigned COUNT_BITS = 16,
  parameter int unsigned CFG_W      = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [trps_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [CFG_W-1:0]                  cfg_data,
  output logic [COUNT_BITS-1:0]             lights_wait_r,
  output logic [PWM_BITS-1:0]               stationary_r,
  output logic [COUNT_BITS-1:0]             train_wait_r,
  output logic [PWM_BITS-1:0]               cruise_r,
  output logic [COUNT_BITS-1:0]             ramp_interval_r,
  output logic [COUNT_BITS-1:0]             brake_interval_r,
  output logic [PWM_BITS-1:0]               downhill_r,
  output logic [PWM_BITS-1:0]               uphill_r
);

  logic [COUNT_BITS-1:0] tick_val;
  logic [PWM_BITS-1:0]   level_val;

  assign tick_val  = cfg_data[COUNT_BITS-1:0];
  assign level_val = cfg_data[PWM_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lights_wait_r    <= '0;
      stationary_r     <= '0;
      train_wait_r     <= '0;
      cruise_r         <= '1;
      ramp_interval_r  <= '0;
      brake_interval_r <= '0;
      downhill_r       <= '0;
      uphill_r         <= '1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        trps_pkg::CFG_LIGHTS_WAIT:    lights_wait_r    <= tick_val;
        trps_pkg::CFG_STATIONARY:     stationary_r     <= level_val;
        trps_pkg::CFG_TRAIN_WAIT:     train_wait_r     <= tick_val;
        trps_pkg::CFG_CRUISE:         cruise_r         <= level_val;
        trps_pkg::CFG_RAMP_INTERVAL:  ramp_interval_r  <= tick_val;
        trps_pkg::CFG_BRAKE_INTERVAL: brake_interval_r <= tick_val;
        trps_pkg::CFG_DOWNHILL_LIMIT: downhill_r       <= level_val;
        trps_pkg::CFG_UPHILL_LIMIT:   uphill_r         <= level_val;
        default: ;
      endcase
    end
  end

endmodule

[rtl/trps_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sequencer step logic
// Shared phase, level and counter state with the per-tick update for the
// start, mountain and brake sequences.
// ----------------------------------------------------------------------------
module trps_step #(
  parameter int unsigned PWM_BITS          = 10,
  parameter int unsigned COUNT_BITS        = 16,
  parameter int unsigned RIGHT_SLOPE_DELAY = 100,
  parameter int unsigned LEFT_SLOPE_DELAY  = 100
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  trps_pkg::func_t       func,
  input  logic [2:0]            contact,
  input  logic [COUNT_BITS-1:0] lights_wait,
  input  logic [PWM_BITS-1:0]   stationary,
  input  logic [COUNT_BITS-1:0] train_wait,
  input  logic [PWM_BITS-1:0]   cruise,
  input  logic [COUNT_BITS-1:0] ramp_interval,
  input  logic [COUNT_BITS-1:0] brake_interval,
  input  logic [PWM_BITS-1:0]   downhill,
  input  logic [PWM_BITS-1:0]   uphill,
  output logic [PWM_BITS-1:0]   res_pwm,
  output trps_pkg::flags_t      res_flags
);

  localparam longint unsigned CNT_MAX = (64'd1 << COUNT_BITS) - 64'd1;
  localparam logic [COUNT_BITS-1:0] RIGHT_DELAY =
    COUNT_BITS'((64'(RIGHT_SLOPE_DELAY) > CNT_MAX) ? CNT_MAX : 64'(RIGHT_SLOPE_DELAY));
  localparam logic [COUNT_BITS-1:0] LEFT_DELAY =
    COUNT_BITS'((64'(LEFT_SLOPE_DELAY) > CNT_MAX) ? CNT_MAX : 64'(LEFT_SLOPE_DELAY));

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  trps_pkg::phase_t      phase_r, phase_nxt;
  logic                  slope_r, slope_nxt;
  logic [PWM_BITS-1:0]   level_r, level_nxt;
  logic [COUNT_BITS-1:0] step_r, step_nxt;
  logic [COUNT_BITS-1:0] sdelay_r, sdelay_nxt;
  logic [COUNT_BITS-1:0] swait_r, swait_nxt;
  logic [COUNT_BITS-1:0] bwait_r, bwait_nxt;

  logic [COUNT_BITS-1:0] interval_sel;
  logic                  ramp_due;
  logic [COUNT_BITS-1:0] step_adv;
  logic [PWM_BITS-1:0]   level_up;
  logic [PWM_BITS-1:0]   level_dn;
  logic                  is_right;
  logic [2:0]            wait_code;
  logic [2:0]            up_code;
  logic [2:0]            down_code;
  logic [COUNT_BITS-1:0] slope_delay;
  logic [PWM_BITS-1:0]   up_lim;
  logic [PWM_BITS-1:0]   down_lim;

  assign interval_sel = (func == trps_pkg::FUNC_BRAKE) ? brake_interval : ramp_interval;
  assign ramp_due     = (step_r >= interval_sel);
  assign step_adv     = ramp_due ? '0 : sat_inc(step_r);
  assign level_up     = (level_r == '1) ? level_r : level_r + 1'b1;
  assign level_dn     = (level_r == '0) ? level_r : level_r - 1'b1;

  assign is_right    = (func == trps_pkg::FUNC_RIGHT);
  assign wait_code   = is_right ? trps_pkg::CONTACT_RIGHT_DOWN : trps_pkg::CONTACT_LEFT_UP;
  assign up_code     = is_right ? trps_pkg::CONTACT_RIGHT_DOWN : trps_pkg::CONTACT_LEFT_DOWN;
  assign down_code   = is_right ? trps_pkg::CONTACT_RIGHT_UP : trps_pkg::CONTACT_LEFT_UP;
  assign slope_delay = is_right ? RIGHT_DELAY : LEFT_DELAY;
  assign up_lim      = is_right ? cruise : uphill;
  assign down_lim    = is_right ? downhill : cruise;

  always_comb begin
    phase_nxt  = phase_r;
    slope_nxt  = slope_r;
    level_nxt  = level_r;
    step_nxt   = step_r;
    sdelay_nxt = sdelay_r;
    swait_nxt  = swait_r;
    bwait_nxt  = bwait_r;
    res_pwm    = '0;
    res_flags  = '0;
    unique case (func)
      trps_pkg::FUNC_START: begin
        unique case (phase_r)
          trps_pkg::PH_FIRST: begin
            if (swait_r >= lights_wait) begin
              phase_nxt = trps_pkg::PH_SECOND;
              swait_nxt = '0;
            end else begin
              swait_nxt = sat_inc(swait_r);
            end
          end
          trps_pkg::PH_SECOND: begin
            res_flags.pwm_write   = 1'b1;
            res_pwm               = stationary;
            level_nxt             = stationary;
            res_flags.brake_write = 1'b1;
            phase_nxt             = trps_pkg::PH_THIRD;
          end
          trps_pkg::PH_THIRD: begin
            if (swait_r >= train_wait) begin
              phase_nxt = trps_pkg::PH_FOURTH;
              swait_nxt = '0;
            end else begin
              swait_nxt = sat_inc(swait_r);
            end
          end
          trps_pkg::PH_FOURTH: begin
            res_flags.pwm_write = 1'b1;
            res_pwm             = level_r;
            if (level_r >= cruise) begin
              phase_nxt          = trps_pkg::PH_FIRST;
              res_flags.done_res = 1'b1;
            end else begin
              level_nxt = ramp_due ? level_up : level_r;
              step_nxt  = step_adv;
            end
          end
          default: phase_nxt = trps_pkg::PH_FIRST;
        endcase
      end
      trps_pkg::FUNC_RIGHT, trps_pkg::FUNC_LEFT: begin
        if (!slope_r) begin
          if ((contact == wait_code) || (sdelay_r >= slope_delay)) begin
            slope_nxt  = 1'b1;
            sdelay_nxt = '0;
          end else begin
            sdelay_nxt = sat_inc(sdelay_r);
          end
        end else if (contact == up_code) begin
          res_flags.pwm_write = 1'b1;
          res_pwm             = level_r;
          if (level_r >= up_lim) begin
            phase_nxt          = trps_pkg::PH_FIRST;
            slope_nxt          = 1'b0;
            res_flags.done_res = 1'b1;
          end else begin
            level_nxt = ramp_due ? level_up : level_r;
            step_nxt  = step_adv;
          end
        end else if (contact == down_code) begin
          res_flags.pwm_write = 1'b1;
          res_pwm             = level_r;
          if (level_r <= down_lim) begin
            phase_nxt          = trps_pkg::PH_FIRST;
            slope_nxt          = 1'b0;
            res_flags.done_res = 1'b1;
          end else begin
            level_nxt = ramp_due ? level_dn : level_r;
            step_nxt  = step_adv;
          end
        end
      end
      trps_pkg::FUNC_BRAKE: begin
        unique case (phase_r)
          trps_pkg::PH_FIRST: begin
            res_flags.pwm_write = 1'b1;
            res_pwm             = level_r;
            if (level_r <= stationary) begin
              phase_nxt = trps_pkg::PH_SECOND;
            end else begin
              level_nxt = ramp_due ? level_dn : level_r;
              step_nxt  = step_adv;
            end
          end
          trps_pkg::PH_SECOND: begin
            if (bwait_r >= train_wait) begin
              phase_nxt = trps_pkg::PH_THIRD;
              bwait_nxt = '0;
            end else begin
              bwait_nxt = sat_inc(bwait_r);
            end
          end
          trps_pkg::PH_THIRD: begin
            res_flags.pwm_write   = 1'b1;
            res_pwm               = stationary;
            level_nxt             = stationary;
            res_flags.brake_write = 1'b1;
            res_flags.brake_on    = 1'b1;
            phase_nxt             = trps_pkg::PH_FOURTH;
          end
          trps_pkg::PH_FOURTH: begin
            if (bwait_r >= lights_wait) begin
              phase_nxt          = trps_pkg::PH_FIRST;
              bwait_nxt          = '0;
              res_flags.done_res = 1'b1;
            end else begin
              bwait_nxt = sat_inc(bwait_r);
            end
          end
          default: phase_nxt = trps_pkg::PH_FIRST;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= trps_pkg::PH_FIRST;
      slope_r  <= 1'b0;
      level_r  <= '0;
      step_r   <= '0;
      sdelay_r <= '0;
      swait_r  <= '0;
      bwait_r  <= '0;
    end else if (adv) begin
      phase_r  <= phase_nxt;
      slope_r  <= slope_nxt;
      level_r  <= level_nxt;
      step_r   <= step_nxt;
      sdelay_r <= sdelay_nxt;
      swait_r  <= swait_nxt;
      bwait_r  <= bwait_nxt;
    end
  end

endmodule

[rtl/train_pwm_ramp_sequencer_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Train PWM ramp sequencer
// Drives the PWM level and brake of a model train through start, mountain
// and brake sequences, one tick per input transfer.
// ----------------------------------------------------------------------------
// Each input transfer is one tick: in_tuser selects the sequence and
// in_tdata carries the reed-contact code. Every tick yields exactly one
// output transfer with the PWM write, brake write and done flags.
// A tick is captured in an input register; once the output register is
// free or draining, the step logic updates the sequencer state and loads
// the output register, and out_tvalid rises. One tick per cycle is
// sustained while the receiver does not stall: the input register is
// refilled in the same cycle that its tick moves to the output register,
// and the state update is made in that same cycle.
// When the receiver stalls, the result waits in the output register and
// one further tick waits in the input register; in_tready then drops.
// Reset clears the state, both valid bits and the settings (cruise level
// and uphill limit to all ones). The user writes settings through the cfg
// port only while no tick is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
`include "train_pwm_ramp_sequencer_top_macros.svh"

module train_pwm_ramp_sequencer_top #(
  parameter int unsigned PWM_BITS          = 10,
  parameter int unsigned COUNT_BITS        = 16,
  parameter int unsigned RIGHT_SLOPE_DELAY = 100,
  parameter int unsigned LEFT_SLOPE_DELAY  = 100
) (
  input  logic                                               clk,
  input  logic                                               rst_n,
  input  logic                                               in_tvalid,
  output logic                                               in_tready,
  // contact[2:0], zero padding above
  input  logic [7:0]                                         in_tdata,
  // func[1:0]
  input  logic [1:0]                                         in_tuser,
  output logic                                               out_tvalid,
  input  logic                                               out_tready,
  // pwm_write, pwm_value, brake_write, brake_on, done_res, zero padding above
  output logic [((PWM_BITS + 11) / 8) * 8 - 1:0]             out_tdata,
  input  logic                                               cfg_we,
  input  logic [trps_pkg::CFG_ADDR_W-1:0]                    cfg_addr,
  input  logic [((COUNT_BITS > PWM_BITS) ? COUNT_BITS : PWM_BITS) - 1:0] cfg_data
);

  localparam int unsigned CFG_W   = (COUNT_BITS > PWM_BITS) ? COUNT_BITS : PWM_BITS;
  localparam int unsigned OUT_W   = ((PWM_BITS + 11) / 8) * 8;
  localparam int unsigned FIELD_W = PWM_BITS + 4;

  logic [COUNT_BITS-1:0] lights_wait;
  logic [PWM_BITS-1:0]   stationary;
  logic [COUNT_BITS-1:0] train_wait;
  logic [PWM_BITS-1:0]   cruise;
  logic [COUNT_BITS-1:0] ramp_interval;
  logic [COUNT_BITS-1:0] brake_interval;
  logic [PWM_BITS-1:0]   downhill;
  logic [PWM_BITS-1:0]   uphill;

  logic                  in_valid_r;
  trps_pkg::func_t       in_func_r;
  logic [2:0]            in_contact_r;
  logic                  out_valid_r;
  logic [PWM_BITS-1:0]   out_pwm_r;
  trps_pkg::flags_t      out_flags_r;
  logic                  adv;
  logic [PWM_BITS-1:0]   res_pwm;
  trps_pkg::flags_t      res_flags;

  trps_cfg #(
    .PWM_BITS   (PWM_BITS),
    .COUNT_BITS (COUNT_BITS),
    .CFG_W      (CFG_W)
  ) u_cfg (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_data         (cfg_data),
    .lights_wait_r    (lights_wait),
    .stationary_r     (stationary),
    .train_wait_r     (train_wait),
    .cruise_r         (cruise),
    .ramp_interval_r  (ramp_interval),
    .brake_interval_r (brake_interval),
    .downhill_r       (downhill),
    .uphill_r         (uphill)
  );

  assign adv       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;

  trps_step #(
    .PWM_BITS          (PWM_BITS),
    .COUNT_BITS        (COUNT_BITS),
    .RIGHT_SLOPE_DELAY (RIGHT_SLOPE_DELAY),
    .LEFT_SLOPE_DELAY  (LEFT_SLOPE_DELAY)
  ) u_step (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (adv),
    .func           (in_func_r),
    .contact        (in_contact_r),
    .lights_wait    (lights_wait),
    .stationary     (stationary),
    .train_wait     (train_wait),
    .cruise         (cruise),
    .ramp_interval  (ramp_interval),
    .brake_interval (brake_interval),
    .downhill       (downhill),
    .uphill         (uphill),
    .res_pwm        (res_pwm),
    .res_flags      (res_flags)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        in_valid_r <= 1'b1;
      end else if (adv) begin
        in_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_func_r    <= trps_pkg::func_t'(in_tuser);
      in_contact_r <= in_tdata[2:0];
    end
    if (adv) begin
      out_pwm_r   <= res_pwm;
      out_flags_r <= res_flags;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({out_flags_r.done_res, out_flags_r.brake_on,
                              out_flags_r.brake_write, out_pwm_r,
                              out_flags_r.pwm_write});

  logic [FIELD_W-1:0] out_fields;
  assign out_fields = out_tdata[FIELD_W-1:0];

  `TRPS_ASSERT_SAME(a_brake_on_needs_write, clk, rst_n,
    out_valid_r && out_flags_r.brake_on, out_flags_r.brake_write)
  `TRPS_ASSERT_SAME(a_pwm_zero_without_write, clk, rst_n,
    out_valid_r && !out_fields[0], out_fields[PWM_BITS:1] == '0)
  `TRPS_ASSERT_SAME(a_done_without_brake_write, clk, rst_n,
    out_valid_r && out_flags_r.done_res, !out_flags_r.brake_write)
  `TRPS_ASSERT_NEXT(a_advance_fills_output, clk, rst_n, adv, out_valid_r)
  `TRPS_ASSERT_SAME(a_ready_when_drained, clk, rst_n,
    out_valid_r && out_tready, in_tready)

endmodule
